// ----- hdl/dbscan_pkg.sv -----
// Package with the shared types, codes and defaults of the DBSCAN clustering unit.
`timescale 1ns / 1ps
package dbscan_pkg;

  localparam int unsigned MaxPointsDefault = 256;
  localparam int unsigned CoordBitsDefault = 12;

  localparam int unsigned EpsBits = 25;
  localparam int unsigned MinBits = 8;

  localparam logic [EpsBits-1:0] EpsReset = 25'd100;
  localparam logic [MinBits-1:0] MinReset = 8'd4;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  localparam logic REG_EPS = 1'b0;
  localparam logic REG_MIN = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  index;
  } cmd_t;

  typedef struct packed {
    logic [8:0] label;
    logic       labelled;
    logic [8:0] num_clusters;
    logic [8:0] point_count;
    logic [1:0] status;
  } rsp_t;

endpackage

// ----- hdl/dbscan_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dbscan_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/dbscan_point_clustering_unit.sv -----
// Top level of the DBSCAN point clustering unit: sequencer, distance unit and stores.
//
// Channel   Direction  Handshake                         Payload
// command   in         start & !busy                     cmd_i  (dbscan_pkg::cmd_t)
// result    out        done_o, one cycle, no back-press  rsp_o  (dbscan_pkg::rsp_t)
// config    in         APB, psel & penable & pwrite      pwdata at paddr 0 (eps), 4 (min)
//
// Clear and load words finish without leaving idle, and a new word may follow at once.
// A read word passes through the read wait state for the label store read.
// A run word first counts the neighbors of every point, then checks each point in turn
// for a new cluster, takes points from the expansion queue and scans all points once more
// for each of those that is core, all on one distance unit.
// Reset is asynchronous and clears the control state; the stores need no clearing.
// The result is shown for one cycle and cannot be stalled.
`timescale 1ns / 1ps
module dbscan_point_clustering_unit #(
  parameter int unsigned MAX_POINTS = dbscan_pkg::MaxPointsDefault,
  parameter int unsigned COORD_BITS = dbscan_pkg::CoordBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dbscan_pkg::cmd_t  cmd_i,
  output logic              done_o,
  output dbscan_pkg::rsp_t  rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned PW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned SW = 2 * CB;
  localparam int unsigned DW = (SW + 1 > dbscan_pkg::EpsBits) ? SW + 1 : dbscan_pkg::EpsBits;
  localparam int unsigned XW = CW + 8;
  localparam int unsigned NB = dbscan_pkg::MinBits;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RDWAIT  = 4'd1;
  localparam logic [3:0] S_CNT_LD  = 4'd2;
  localparam logic [3:0] S_CNT_CAP = 4'd3;
  localparam logic [3:0] S_J_RD    = 4'd4;
  localparam logic [3:0] S_J_DIFF  = 4'd5;
  localparam logic [3:0] S_J_SQ    = 4'd6;
  localparam logic [3:0] S_J_CMP   = 4'd7;
  localparam logic [3:0] S_CNT_END = 4'd8;
  localparam logic [3:0] S_OUT_RD  = 4'd9;
  localparam logic [3:0] S_OUT_CHK = 4'd10;
  localparam logic [3:0] S_Q_RD    = 4'd11;
  localparam logic [3:0] S_Q_ADR   = 4'd12;
  localparam logic [3:0] S_Q_CHK   = 4'd13;

  logic [3:0] state_q, state_d;
  logic [dbscan_pkg::EpsBits-1:0] eps_q, eps_d;
  logic [NB-1:0] minn_q, minn_d;
  logic [CW-1:0] loaded_q, loaded_d, lab_cnt_q, lab_cnt_d, clusters_q, clusters_d;
  logic [CW-1:0] ctr_q, ctr_d, j_q, j_d, head_q, head_d, tail_q, tail_d;
  logic [PW-1:0] q_q, q_d;
  logic phase_q, phase_d;
  logic [CB-1:0] cx_q, cx_d, cy_q, cy_d, dx_q, dx_d, dy_q, dy_d;
  logic [SW-1:0] sqx_q, sqx_d, sqy_q, sqy_d;
  logic [CW-1:0] lbl_q, lbl_d;
  logic [NB-1:0] cnt_q, cnt_d;
  logic labelled_q, labelled_d;
  logic done_q, done_d;
  dbscan_pkg::rsp_t rsp_q, rsp_d;

  logic xy_we, lab_we, ncnt_we, que_we;
  logic [PW-1:0] xy_waddr, xy_raddr, lab_waddr, lab_raddr, ncnt_waddr, ncnt_raddr;
  logic [PW-1:0] que_waddr, que_raddr, que_wdata;
  logic [CB-1:0] x_wdata, y_wdata, x_rdata, y_rdata;
  logic [CW-1:0] lab_wdata, lab_rdata;
  logic [NB-1:0] ncnt_wdata, ncnt_rdata;
  logic [PW-1:0] que_rdata;

  logic cfg_wr;
  logic near;
  logic [PW-1:0] center;
  logic [CW-1:0] j_nx, ctr_nx;
  logic idx_ok;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == dbscan_pkg::REG_MIN) ? 32'(minn_q) : 32'(eps_q);
  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign center = phase_q ? q_q : ctr_q[PW-1:0];
  assign near   = (j_q[PW-1:0] != center) &&
                  ((DW'(sqx_q) + DW'(sqy_q)) <= DW'(eps_q));
  assign j_nx   = j_q + CW'(1);
  assign ctr_nx = ctr_q + CW'(1);
  assign idx_ok = XW'(cmd_i.index) < XW'(loaded_q);

  always_comb begin
    state_d    = state_q;
    eps_d      = eps_q;
    minn_d     = minn_q;
    loaded_d   = loaded_q;
    lab_cnt_d  = lab_cnt_q;
    clusters_d = clusters_q;
    ctr_d      = ctr_q;
    j_d        = j_q;
    head_d     = head_q;
    tail_d     = tail_q;
    q_d        = q_q;
    phase_d    = phase_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    sqx_d      = sqx_q;
    sqy_d      = sqy_q;
    lbl_d      = lbl_q;
    cnt_d      = cnt_q;
    labelled_d = labelled_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;

    xy_we      = 1'b0;
    xy_waddr   = loaded_q[PW-1:0];
    x_wdata    = CB'(cmd_i.x);
    y_wdata    = CB'(cmd_i.y);
    xy_raddr   = j_q[PW-1:0];
    lab_we     = 1'b0;
    lab_waddr  = j_q[PW-1:0];
    lab_wdata  = clusters_q;
    lab_raddr  = j_q[PW-1:0];
    ncnt_we    = 1'b0;
    ncnt_waddr = ctr_q[PW-1:0];
    ncnt_wdata = cnt_q;
    ncnt_raddr = ctr_q[PW-1:0];
    que_we     = 1'b0;
    que_waddr  = tail_q[PW-1:0];
    que_wdata  = j_q[PW-1:0];
    que_raddr  = head_q[PW-1:0];

    if (cfg_wr) begin
      if (paddr[2] == dbscan_pkg::REG_MIN) begin
        minn_d = pwdata[NB-1:0];
      end else begin
        eps_d = pwdata[dbscan_pkg::EpsBits-1:0];
      end
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          rsp_d.label    = '0;
          rsp_d.labelled = 1'b0;
          rsp_d.status   = dbscan_pkg::ST_OK;
          case (cmd_i.opcode)
            dbscan_pkg::OP_CLEAR: begin
              loaded_d   = '0;
              clusters_d = '0;
              done_d     = 1'b1;
            end
            dbscan_pkg::OP_LOAD: begin
              if (loaded_q == CW'(MAX_POINTS)) begin
                rsp_d.status = dbscan_pkg::ST_FULL;
              end else begin
                xy_we    = 1'b1;
                loaded_d = loaded_q + CW'(1);
                if (lab_cnt_q > loaded_q) begin
                  lab_cnt_d = loaded_q;
                end
              end
              done_d = 1'b1;
            end
            dbscan_pkg::OP_RUN: begin
              clusters_d = '0;
              lab_cnt_d  = loaded_q;
              ctr_d      = '0;
              phase_d    = 1'b0;
              if (loaded_q == '0) begin
                done_d = 1'b1;
              end else begin
                state_d = S_CNT_LD;
              end
            end
            default: begin
              if (idx_ok) begin
                lab_raddr  = PW'(cmd_i.index);
                labelled_d = XW'(cmd_i.index) < XW'(lab_cnt_q);
                state_d    = S_RDWAIT;
              end else begin
                rsp_d.status = dbscan_pkg::ST_BAD_INDEX;
                done_d       = 1'b1;
              end
            end
          endcase
          rsp_d.num_clusters = 9'(clusters_d);
          rsp_d.point_count  = 9'(loaded_d);
        end
      end
      S_RDWAIT: begin
        rsp_d.label    = labelled_q ? 9'(lab_rdata) : 9'd0;
        rsp_d.labelled = labelled_q;
        done_d         = 1'b1;
        state_d        = S_IDLE;
      end
      S_CNT_LD: begin
        xy_raddr = ctr_q[PW-1:0];
        state_d  = S_CNT_CAP;
      end
      S_CNT_CAP: begin
        cx_d    = x_rdata;
        cy_d    = y_rdata;
        j_d     = '0;
        cnt_d   = '0;
        state_d = S_J_RD;
      end
      S_J_RD: begin
        state_d = S_J_DIFF;
      end
      S_J_DIFF: begin
        dx_d    = (cx_q >= x_rdata) ? cx_q - x_rdata : x_rdata - cx_q;
        dy_d    = (cy_q >= y_rdata) ? cy_q - y_rdata : y_rdata - cy_q;
        lbl_d   = lab_rdata;
        state_d = S_J_SQ;
      end
      S_J_SQ: begin
        sqx_d   = SW'(dx_q) * SW'(dx_q);
        sqy_d   = SW'(dy_q) * SW'(dy_q);
        state_d = S_J_CMP;
      end
      S_J_CMP: begin
        if (!phase_q) begin
          if (near && (cnt_q != {NB{1'b1}})) begin
            cnt_d = cnt_q + NB'(1);
          end
        end else if (near && (lbl_q == '0)) begin
          lab_we = 1'b1;
          if (j_q > ctr_q) begin
            que_we = 1'b1;
            tail_d = tail_q + CW'(1);
          end
        end
        if (j_nx == loaded_q) begin
          if (!phase_q) begin
            state_d = S_CNT_END;
          end else if (head_q != tail_d) begin
            state_d = S_Q_RD;
          end else if (ctr_nx == loaded_q) begin
            done_d             = 1'b1;
            rsp_d.num_clusters = 9'(clusters_q);
            state_d            = S_IDLE;
          end else begin
            ctr_d   = ctr_nx;
            state_d = S_OUT_RD;
          end
        end else begin
          j_d     = j_nx;
          state_d = S_J_RD;
        end
      end
      S_CNT_END: begin
        ncnt_we   = 1'b1;
        lab_we    = 1'b1;
        lab_waddr = ctr_q[PW-1:0];
        lab_wdata = '0;
        if (ctr_nx == loaded_q) begin
          ctr_d   = '0;
          state_d = S_OUT_RD;
        end else begin
          ctr_d   = ctr_nx;
          state_d = S_CNT_LD;
        end
      end
      S_OUT_RD: begin
        lab_raddr = ctr_q[PW-1:0];
        state_d   = S_OUT_CHK;
      end
      S_OUT_CHK: begin
        if ((lab_rdata != '0) || (ncnt_rdata < minn_q)) begin
          if (ctr_nx == loaded_q) begin
            done_d             = 1'b1;
            rsp_d.num_clusters = 9'(clusters_q);
            state_d            = S_IDLE;
          end else begin
            ctr_d   = ctr_nx;
            state_d = S_OUT_RD;
          end
        end else begin
          clusters_d = clusters_q + CW'(1);
          lab_we     = 1'b1;
          lab_waddr  = ctr_q[PW-1:0];
          lab_wdata  = clusters_d;
          que_we     = 1'b1;
          que_waddr  = '0;
          que_wdata  = ctr_q[PW-1:0];
          head_d     = '0;
          tail_d     = CW'(1);
          phase_d    = 1'b1;
          state_d    = S_Q_RD;
        end
      end
      S_Q_RD: begin
        state_d = S_Q_ADR;
      end
      S_Q_ADR: begin
        q_d        = que_rdata;
        xy_raddr   = que_rdata;
        ncnt_raddr = que_rdata;
        head_d     = head_q + CW'(1);
        state_d    = S_Q_CHK;
      end
      S_Q_CHK: begin
        cx_d = x_rdata;
        cy_d = y_rdata;
        if (ncnt_rdata >= minn_q) begin
          j_d     = '0;
          state_d = S_J_RD;
        end else if (head_q != tail_q) begin
          state_d = S_Q_RD;
        end else if (ctr_nx == loaded_q) begin
          done_d             = 1'b1;
          rsp_d.num_clusters = 9'(clusters_q);
          state_d            = S_IDLE;
        end else begin
          ctr_d   = ctr_nx;
          state_d = S_OUT_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      eps_q      <= dbscan_pkg::EpsReset;
      minn_q     <= dbscan_pkg::MinReset;
      loaded_q   <= '0;
      lab_cnt_q  <= '0;
      clusters_q <= '0;
      ctr_q      <= '0;
      j_q        <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      phase_q    <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      eps_q      <= eps_d;
      minn_q     <= minn_d;
      loaded_q   <= loaded_d;
      lab_cnt_q  <= lab_cnt_d;
      clusters_q <= clusters_d;
      ctr_q      <= ctr_d;
      j_q        <= j_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      phase_q    <= phase_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q        <= q_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    sqx_q      <= sqx_d;
    sqy_q      <= sqy_d;
    lbl_q      <= lbl_d;
    cnt_q      <= cnt_d;
    labelled_q <= labelled_d;
    rsp_q      <= rsp_d;
  end

  dbscan_ram #(.WIDTH(CB), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk_i(clk_i), .we_i(xy_we), .waddr_i(xy_waddr), .wdata_i(x_wdata),
    .raddr_i(xy_raddr), .rdata_o(x_rdata)
  );

  dbscan_ram #(.WIDTH(CB), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk_i(clk_i), .we_i(xy_we), .waddr_i(xy_waddr), .wdata_i(y_wdata),
    .raddr_i(xy_raddr), .rdata_o(y_rdata)
  );

  dbscan_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_label_ram (
    .clk_i(clk_i), .we_i(lab_we), .waddr_i(lab_waddr), .wdata_i(lab_wdata),
    .raddr_i(lab_raddr), .rdata_o(lab_rdata)
  );

  dbscan_ram #(.WIDTH(NB), .DEPTH(MAX_POINTS)) u_ncnt_ram (
    .clk_i(clk_i), .we_i(ncnt_we), .waddr_i(ncnt_waddr), .wdata_i(ncnt_wdata),
    .raddr_i(ncnt_raddr), .rdata_o(ncnt_rdata)
  );

  dbscan_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_queue_ram (
    .clk_i(clk_i), .we_i(que_we), .waddr_i(que_waddr), .wdata_i(que_wdata),
    .raddr_i(que_raddr), .rdata_o(que_rdata)
  );

endmodule

// ----- hdl/dbscan_checker.sv -----
// Port-level assertions for the DBSCAN point clustering unit, bound to its top level.
`timescale 1ns / 1ps
module dbscan_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input dbscan_pkg::cmd_t cmd_i,
  input logic             done_o,
  input dbscan_pkg::rsp_t rsp_o
);

  logic acc;
  assign acc = start && !busy;

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (cmd_i.opcode == dbscan_pkg::OP_CLEAR) |=>
      done_o && (rsp_o.point_count == 9'd0) && (rsp_o.num_clusters == 9'd0))
    else $error("A clear word did not give an empty result next cycle.");

  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (cmd_i.opcode == dbscan_pkg::OP_LOAD) |=> done_o && !busy)
    else $error("A load word did not finish in one cycle.");

  a_bad_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == dbscan_pkg::ST_BAD_INDEX) |->
      (rsp_o.label == 9'd0) && !rsp_o.labelled)
    else $error("A read of an unloaded index returned a label.");

  a_labelled_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.labelled |-> (rsp_o.status == dbscan_pkg::ST_OK))
    else $error("A labelled result carried an error status.");

endmodule

bind dbscan_point_clustering_unit dbscan_checker u_dbscan_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .cmd_i(cmd_i), .done_o(done_o), .rsp_o(rsp_o)
);
